FILE: hw/rtl/multibyte_char_segmenter_top_assert.svh
// Assertion macros shared by the segmenter modules.
// Each macro expects the module to have clk and arst_n in scope.
`ifndef MULTIBYTE_CHAR_SEGMENTER_TOP_ASSERT_SVH
`define MULTIBYTE_CHAR_SEGMENTER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBSEG_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBSEG_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/mbseg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mbseg_pkg;

	typedef enum logic [1:0] {
		MODE_GB2312  = 2'd0,
		MODE_BIG5    = 2'd1,
		MODE_GB18030 = 2'd2,
		MODE_UTF8    = 2'd3
	} mode_t;

	// Range flags of one byte, computed once when the byte enters.
	typedef struct packed {
		logic       nul;
		logic       below_80;
		logic       gb_single;
		logic       trail2;
		logic       digit;
		logic       trail3;
		logic [2:0] utf_len;
	} class_t;

	localparam int CLASS_BITS = $bits(class_t);

	typedef struct packed {
		logic [7:0] data;
		class_t     cls;
	} q_item_t;

	// Decision on the character at the head of the held bytes.
	// A length of zero marks the end of the string.
	typedef struct packed {
		logic       more;
		logic [2:0] len;
	} head_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	function automatic head_t head_len(class_t [3:0] c, logic [2:0] n, mode_t mode);
		head_t h;
		h.more = 1'b0;
		h.len = 3'd1;
		if (c[0].nul) begin
			h.len = 3'd0;
		end else begin
			case (mode)
				MODE_GB2312, MODE_BIG5: begin
					if (c[0].below_80) h.len = 3'd1;
					else if (n >= 3'd2) h.len = 3'd2;
					else h.more = 1'b1;
				end
				MODE_GB18030: begin
					if (c[0].gb_single) h.len = 3'd1;
					else if (n < 3'd2) h.more = 1'b1;
					else if (c[1].trail2) h.len = 3'd2;
					else if (!c[1].digit) h.len = 3'd1;
					else if (n < 3'd3) h.more = 1'b1;
					else if (!c[2].trail3) h.len = 3'd1;
					else if (n < 3'd4) h.more = 1'b1;
					else h.len = c[3].digit ? 3'd4 : 3'd1;
				end
				MODE_UTF8: begin
					h.len = c[0].utf_len;
					h.more = (c[0].utf_len > n);
				end
				default: begin
					h.len = c[0].utf_len;
					h.more = (c[0].utf_len > n);
				end
			endcase
		end
		return h;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/multibyte_char_segmenter_top.sv
// Multibyte character segmenter: bytes enter on the in channel, one per item,
// and leave grouped into characters under the encoding held in the one
// configuration register (0 GB2312, 1 Big5, 2 GB18030, 3 UTF-8, reset 3),
// which must be written only while no bytes are in flight. A four-entry input
// queue decouples the byte input from the decoder; the decoder absorbs a byte
// and then releases in turn each character result that the byte completes,
// up to four when a failed GB18030 check lets them go together. It takes no
// new byte until it has released every result of the last, and a stalled
// output holds it. Each result carries the packed character, its byte count,
// the saturating per-string count and a flag marking the final result caused
// by the byte; a NUL lead byte yields an end-of-string item and restarts the
// count.
`timescale 1ns / 1ps
`default_nettype none

module multibyte_char_segmenter_top #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      char_value,
	output logic [2:0]       byte_count,
	output logic [15:0]      char_count,
	output logic             end_of_string,
	output logic             last_result
);

	mbseg_pkg::mode_t      encoding_mode_q;
	logic                  q_valid;
	mbseg_pkg::q_item_t    q_item;
	logic                  q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encoding_mode_q <= mbseg_pkg::MODE_UTF8;
		end else if (cfg_valid && cfg_ready) begin
			encoding_mode_q <= mbseg_pkg::mode_t'(cfg_data);
		end
	end

	mbseg_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	mbseg_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.mode          (encoding_mode_q),
		.q_valid       (q_valid),
		.q_item        (q_item),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.char_value    (char_value),
		.byte_count    (byte_count),
		.char_count    (char_count),
		.end_of_string (end_of_string),
		.last_result   (last_result)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/mbseg_front.sv
`timescale 1ns / 1ps
`default_nettype none

module mbseg_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          in_byte,
	output logic                     q_valid,
	output mbseg_pkg::q_item_t       q_item,
	input  wire logic                q_pop
);

	`include "multibyte_char_segmenter_top_assert.svh"

	mbseg_pkg::q_item_t                     mem_q [mbseg_pkg::QUEUE_DEPTH];
	logic [mbseg_pkg::QPTR_W-1:0]           wr_ptr_q;
	logic [mbseg_pkg::QPTR_W-1:0]           rd_ptr_q;
	logic [mbseg_pkg::QCNT_W-1:0]           count_q;
	mbseg_pkg::class_t                      cls;
	logic                                   push;
	logic                                   pop;

	always_comb begin
		cls.nul = (in_byte == 8'h00);
		cls.below_80 = (in_byte < 8'h80);
		cls.gb_single = (in_byte <= 8'h80) || (in_byte == 8'hff);
		cls.trail2 = (in_byte >= 8'h40) && (in_byte <= 8'hfe) && (in_byte != 8'h7f);
		cls.digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
		cls.trail3 = (in_byte >= 8'h81) && (in_byte <= 8'hfe);
		if (in_byte < 8'h80) cls.utf_len = 3'd1;
		else if (in_byte < 8'he0) cls.utf_len = 3'd2;
		else if (in_byte < 8'hf0) cls.utf_len = 3'd3;
		else cls.utf_len = 3'd4;
	end

	assign in_stall = (count_q == mbseg_pkg::QCNT_W'(mbseg_pkg::QUEUE_DEPTH));
	assign push = in_valid && !in_stall;
	assign q_valid = (count_q != '0);
	assign pop = q_pop && q_valid;
	assign q_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: in_byte, cls: cls};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + mbseg_pkg::QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + mbseg_pkg::QPTR_W'(1);
			if (push && !pop) count_q <= count_q + mbseg_pkg::QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - mbseg_pkg::QCNT_W'(1);
		end
	end

	`MBSEG_ASSERT_NOW(a_queue_bound, 1'b1,
		count_q <= mbseg_pkg::QCNT_W'(mbseg_pkg::QUEUE_DEPTH),
		"Queue holds more items than its depth.")
	`MBSEG_ASSERT_NEXT(a_queue_empty_no_pop, !q_valid && !push,
		count_q == '0, "Empty queue changed without a push.")

endmodule

`default_nettype wire

FILE: hw/rtl/mbseg_back.sv
`timescale 1ns / 1ps
`default_nettype none

module mbseg_back #(
	parameter int COUNT_BITS = 16
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire mbseg_pkg::mode_t    mode,
	input  wire logic                q_valid,
	input  wire mbseg_pkg::q_item_t  q_item,
	output logic                     q_pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [31:0]              char_value,
	output logic [2:0]               byte_count,
	output logic [15:0]              char_count,
	output logic                     end_of_string,
	output logic                     last_result
);

	`include "multibyte_char_segmenter_top_assert.svh"

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t                          st_q;
	logic [3:0][7:0]                 hb_q;
	mbseg_pkg::class_t [3:0]         hc_q;
	logic [2:0]                      cnt_q;
	logic [COUNT_BITS-1:0]           chars_q;
	logic                            out_valid_q;
	logic [31:0]                     value_q;
	logic [2:0]                      bc_q;
	logic [15:0]                     count_q;
	logic                            eos_q;
	logic                            last_q;

	mbseg_pkg::head_t                cur;
	mbseg_pkg::head_t                rem;
	logic [2:0]                      used;
	logic [2:0]                      rem_n;
	logic [3:0][7:0]                 rb;
	mbseg_pkg::class_t [3:0]         rc;
	logic [31:0]                     value;
	logic [COUNT_BITS-1:0]           chars_sat;
	logic                            load;
	logic                            emit;
	logic                            last;

	assign cur = mbseg_pkg::head_len(hc_q, cnt_q, mode);
	assign used = (cur.len == 3'd0) ? 3'd1 : cur.len;
	assign rem_n = cnt_q - used;

	always_comb begin
		case (used)
			3'd2: begin
				rb = {16'h0, hb_q[3:2]};
				rc = {{(2 * mbseg_pkg::CLASS_BITS){1'b0}}, hc_q[3:2]};
			end
			3'd3: begin
				rb = {24'h0, hb_q[3]};
				rc = {{(3 * mbseg_pkg::CLASS_BITS){1'b0}}, hc_q[3]};
			end
			3'd4: begin
				rb = '0;
				rc = '0;
			end
			default: begin
				rb = {8'h0, hb_q[3:1]};
				rc = {{mbseg_pkg::CLASS_BITS{1'b0}}, hc_q[3:1]};
			end
		endcase
	end

	assign rem = mbseg_pkg::head_len(rc, rem_n, mode);
	assign last = (rem_n == 3'd0) || rem.more;

	always_comb begin
		case (cur.len)
			3'd1: value = {24'h0, hb_q[0]};
			3'd2: value = {16'h0, hb_q[0], hb_q[1]};
			3'd3: value = {8'h0, hb_q[0], hb_q[1], hb_q[2]};
			3'd4: value = {hb_q[0], hb_q[1], hb_q[2], hb_q[3]};
			default: value = 32'h0;
		endcase
	end

	assign chars_sat = (&chars_q) ? chars_q : chars_q + COUNT_BITS'(1);
	assign load = (st_q == ST_IDLE) && q_valid;
	assign q_pop = load;
	assign emit = (st_q == ST_RUN) && !cur.more && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= 3'd0;
			chars_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (load) begin
						cnt_q <= cnt_q + 3'd1;
						st_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cur.more) begin
						st_q <= ST_IDLE;
					end else if (emit) begin
						cnt_q <= rem_n;
						if (last) st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
			if (emit) begin
				chars_q <= (cur.len == 3'd0) ? '0 : chars_sat;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			hb_q[cnt_q[1:0]] <= q_item.data;
			hc_q[cnt_q[1:0]] <= q_item.cls;
		end else if (emit) begin
			hb_q <= rb;
			hc_q <= rc;
		end
		if (emit) begin
			value_q <= value;
			bc_q <= cur.len;
			count_q <= (cur.len == 3'd0) ? 16'(chars_q) : 16'(chars_sat);
			eos_q <= (cur.len == 3'd0);
			last_q <= last;
		end
	end

	assign out_valid = out_valid_q;
	assign char_value = value_q;
	assign byte_count = bc_q;
	assign char_count = count_q;
	assign end_of_string = eos_q;
	assign last_result = last_q;

	`MBSEG_ASSERT_NOW(a_idle_held_bound, st_q == ST_IDLE, cnt_q <= 3'd3,
		"Idle with a full set of held bytes.")
	`MBSEG_ASSERT_NEXT(a_last_goes_idle, emit && last, st_q == ST_IDLE,
		"Final result of a byte did not end its step.")
	`MBSEG_ASSERT_NOW(a_marker_empty, out_valid_q && eos_q,
		(value_q == 32'h0) && (bc_q == 3'd0), "End marker carries character data.")
	`MBSEG_ASSERT_NOW(a_char_nonempty, out_valid_q && !eos_q, bc_q != 3'd0,
		"Character result with no bytes.")

endmodule

`default_nettype wire

FILE: test/multibyte_char_segmenter_top_test.sv
`timescale 1ns / 1ps

module multibyte_char_segmenter_top_test;

	localparam int COUNT_BITS = 16;
	localparam int unsigned COUNT_CAP = (1 << COUNT_BITS) - 1;
	localparam int SETTLE_CYCLES = 24;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  nbytes;
		logic [15:0] count;
		logic        is_end;
		logic        is_last;
	} char_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_data = 2'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  in_byte = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [31:0] char_value;
	logic [2:0]  byte_count;
	logic [15:0] char_count;
	logic        end_of_string;
	logic        last_result;

	logic [7:0]   byte_backlog[$];
	char_result_t pending_chars[$];

	mbseg_pkg::mode_t cur_mode = mbseg_pkg::MODE_UTF8;
	logic [7:0]  held[4];
	int          held_n = 0;
	int unsigned str_chars = 0;

	int send_idle = 0;
	int recv_idle = 0;
	int error_count = 0;

	multibyte_char_segmenter_top #(
		.COUNT_BITS(COUNT_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_byte(in_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_value(char_value),
		.byte_count(byte_count),
		.char_count(char_count),
		.end_of_string(end_of_string),
		.last_result(last_result)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("multibyte_char_segmenter_top_test: errors");
		$finish;
	end

	task automatic report(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	function automatic void queue_byte(logic [7:0] b);
		byte_backlog = {byte_backlog, b};
	endfunction

	function automatic bit in_span(logic [7:0] v, logic [7:0] lo, logic [7:0] hi);
		return v >= lo && v <= hi;
	endfunction

	// Length of the character at the head of the held bytes: 1..4, 0 for the
	// end marker, -1 while more bytes are needed.
	function automatic int char_span(int n);
		logic [7:0] lead;
		int len;
		lead = held[0];
		if (lead == 8'h00) return 0;
		case (cur_mode)
			mbseg_pkg::MODE_GB2312, mbseg_pkg::MODE_BIG5: begin
				if (lead < 8'h80) return 1;
				return (n >= 2) ? 2 : -1;
			end
			mbseg_pkg::MODE_GB18030: begin
				if (lead <= 8'h80 || lead == 8'hff) return 1;
				if (n < 2) return -1;
				if (in_span(held[1], 8'h40, 8'hfe) && held[1] != 8'h7f) return 2;
				if (!in_span(held[1], 8'h30, 8'h39)) return 1;
				if (n < 3) return -1;
				if (!in_span(held[2], 8'h81, 8'hfe)) return 1;
				if (n < 4) return -1;
				return in_span(held[3], 8'h30, 8'h39) ? 4 : 1;
			end
			default: begin
				if (lead < 8'h80) len = 1;
				else if (lead < 8'he0) len = 2;
				else if (lead < 8'hf0) len = 3;
				else len = 4;
				return (len <= n) ? len : -1;
			end
		endcase
	endfunction

	function automatic void absorb_byte(logic [7:0] b);
		int n;
		int len;
		int used;
		int produced;
		logic [31:0] v;
		char_result_t r;
		n = (held_n > 3) ? 3 : held_n;
		held[n] = b;
		n++;
		produced = 0;
		while (n > 0 && produced < 4) begin
			len = char_span(n);
			if (len < 0) break;
			if (len == 0) begin
				r.value = 32'd0;
				r.nbytes = 3'd0;
				r.count = str_chars[15:0];
				r.is_end = 1'b1;
				str_chars = 0;
				used = 1;
			end else begin
				v = 32'd0;
				for (int i = 0; i < len; i++) v = {v[23:0], held[i]};
				if (str_chars < COUNT_CAP) str_chars++;
				r.value = v;
				r.nbytes = 3'(len);
				r.count = str_chars[15:0];
				r.is_end = 1'b0;
				used = len;
			end
			r.is_last = 1'b0;
			pending_chars = {pending_chars, r};
			produced++;
			for (int i = 0; i < n - used; i++) held[i] = held[i + used];
			n -= used;
		end
		if (produced > 0) pending_chars[pending_chars.size() - 1].is_last = 1'b1;
		held_n = n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= 8'd0;
		end else begin
			if (in_valid && !in_stall) absorb_byte(in_byte);
			if (!in_valid || !in_stall) begin
				if (byte_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					in_valid <= 1'b1;
					in_byte <= byte_backlog.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		char_result_t got;
		char_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				got = '{char_value, byte_count, char_count, end_of_string, last_result};
				if (pending_chars.size() == 0) begin
					report($sformatf("unexpected item value=%h bytes=%0d count=%0d end=%b last=%b",
						got.value, got.nbytes, got.count, got.is_end, got.is_last));
				end else begin
					want = pending_chars.pop_front();
					if (got !== want) begin
						report($sformatf("got %h/%0d/%0d/%b/%b want %h/%0d/%0d/%b/%b",
							got.value, got.nbytes, got.count, got.is_end, got.is_last,
							want.value, want.nbytes, want.count, want.is_end, want.is_last));
					end
				end
			end
			out_stall <= ($urandom_range(0, 99) < recv_idle);
		end
	end

	task automatic settle_all();
		do @(negedge clk);
		while (byte_backlog.size() != 0 || in_valid || pending_chars.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_mode(input mbseg_pkg::mode_t m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= m;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_mode = m;
	endtask

	function automatic int push_char(mbseg_pkg::mode_t m);
		int pick;
		int len;
		logic [7:0] t;
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			queue_byte(8'h00);
			return 1;
		end
		if (pick < 14) begin
			queue_byte(8'($urandom_range(0, 255)));
			return 1;
		end
		case (m)
			mbseg_pkg::MODE_GB2312, mbseg_pkg::MODE_BIG5: begin
				if ($urandom_range(0, 1) == 0) begin
					queue_byte(8'($urandom_range(1, 8'h7f)));
					return 1;
				end
				queue_byte(8'($urandom_range(8'h80, 8'hff)));
				queue_byte(8'($urandom_range(0, 255)));
				return 2;
			end
			mbseg_pkg::MODE_GB18030: begin
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					if ($urandom_range(0, 1) == 0) queue_byte(8'($urandom_range(1, 8'h80)));
					else queue_byte(8'hff);
					return 1;
				end
				queue_byte(8'($urandom_range(8'h81, 8'hfe)));
				if (pick < 6) begin
					do t = 8'($urandom_range(8'h40, 8'hfe));
					while (t == 8'h7f);
					queue_byte(t);
					return 2;
				end
				queue_byte(8'($urandom_range(8'h30, 8'h39)));
				if (pick < 9) begin
					queue_byte(8'($urandom_range(8'h81, 8'hfe)));
					queue_byte(8'($urandom_range(8'h30, 8'h39)));
					return 4;
				end
				queue_byte(8'($urandom_range(0, 255)));
				queue_byte(8'($urandom_range(0, 255)));
				return 4;
			end
			default: begin
				len = $urandom_range(1, 4);
				case (len)
					1: queue_byte(8'($urandom_range(1, 8'h7f)));
					2: queue_byte(8'($urandom_range(8'h80, 8'hdf)));
					3: queue_byte(8'($urandom_range(8'he0, 8'hef)));
					default: queue_byte(8'($urandom_range(8'hf0, 8'hff)));
				endcase
				for (int i = 1; i < len; i++) begin
					if ($urandom_range(0, 3) != 0) queue_byte(8'($urandom_range(8'h80, 8'hbf)));
					else queue_byte(8'($urandom_range(0, 255)));
				end
				return len;
			end
		endcase
	endfunction

	task automatic random_phase(input mbseg_pkg::mode_t m, input int nbytes);
		int added;
		set_mode(m);
		added = 0;
		while (added < nbytes) added += push_char(m);
		settle_all();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle = 30;
		recv_idle = 88;

		// UTF-8 from the reset value: lengths one to four, a zero inside a
		// character, then the end of the string.
		byte_backlog = {byte_backlog, 8'h7f, 8'hdf, 8'h00, 8'hef, 8'hbf, 8'hbf,
			8'hff, 8'h80, 8'h80, 8'h80, 8'h00};
		settle_all();

		// GB18030: single bytes, a failed two-byte check, an early failure on
		// the third byte, a good four-byte code, a failure on the fourth byte
		// that releases four items, and a partial code left held.
		set_mode(mbseg_pkg::MODE_GB18030);
		byte_backlog = {byte_backlog, 8'h80, 8'h81, 8'h7f, 8'h81, 8'h30, 8'h20,
			8'h82, 8'h31, 8'hfe, 8'h39, 8'h82, 8'h31, 8'h82, 8'h29, 8'h81, 8'h35};
		settle_all();

		// The held bytes are judged again under the new mode.
		set_mode(mbseg_pkg::MODE_GB2312);
		queue_byte(8'h41);
		settle_all();

		random_phase(mbseg_pkg::MODE_BIG5, 35);
		random_phase(mbseg_pkg::MODE_GB18030, 35);
		random_phase(mbseg_pkg::MODE_UTF8, 35);
		random_phase(mbseg_pkg::MODE_GB2312, 35);

		send_idle = 88;
		recv_idle = 30;
		random_phase(mbseg_pkg::MODE_GB18030, 35);
		random_phase(mbseg_pkg::MODE_GB2312, 35);
		random_phase(mbseg_pkg::MODE_UTF8, 35);
		random_phase(mbseg_pkg::MODE_BIG5, 35);

		send_idle = 0;
		recv_idle = 0;
		random_phase(mbseg_pkg::MODE_GB2312, 35);
		random_phase(mbseg_pkg::MODE_BIG5, 35);
		random_phase(mbseg_pkg::MODE_GB18030, 35);
		random_phase(mbseg_pkg::MODE_UTF8, 35);

		if (error_count == 0) begin
			$display("multibyte_char_segmenter_top_test: clean");
		end else begin
			$display("multibyte_char_segmenter_top_test: errors");
		end
		$finish;
	end

endmodule
